// ===== src/hsbrgb_pkg.sv =====
// Shared types, the dimming curve ROM and stage word layouts for the HSB to RGB converter.
// No dependencies.

package hsbrgb_pkg;

    localparam int unsigned SECTOR_SPAN = 43;
    // ceil(2^19 / 43): exact floor division for every product below 47662
    localparam int unsigned RECIP_SHIFT = 19;
    localparam logic [13:0] RECIP_43    = 14'd12193;

    localparam logic [7:0] SAT_FULL = 8'd255;

    localparam logic [2:0] SECTOR_RED_YEL  = 3'd0;
    localparam logic [2:0] SECTOR_YEL_GRN  = 3'd1;
    localparam logic [2:0] SECTOR_GRN_CYN  = 3'd2;
    localparam logic [2:0] SECTOR_CYN_BLU  = 3'd3;
    localparam logic [2:0] SECTOR_BLU_MAG  = 3'd4;
    localparam logic [2:0] SECTOR_MAG_RED  = 3'd5;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } hsb_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // After the ROM lookups
    typedef struct packed {
        logic [7:0] v;
        logic [7:0] sat_inv;   // 255 - adjusted saturation
        logic [2:0] sector;
        logic [5:0] rem;
        logic       black;
        logic       grey;
    } lkp_word_t;

    // After p is formed
    typedef struct packed {
        logic [7:0] v;
        logic [7:0] p;
        logic [2:0] sector;
        logic [5:0] rem;
        logic       black;
        logic       grey;
    } pval_word_t;

    // After the span products
    typedef struct packed {
        logic [7:0]  v;
        logic [7:0]  p;
        logic [13:0] prod_q;
        logic [13:0] prod_t;
        logic [2:0]  sector;
        logic        black;
        logic        grey;
    } prod_word_t;

    // After the divide by 43
    typedef struct packed {
        logic [7:0] v;
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] t;
        logic [2:0] sector;
        logic       black;
        logic       grey;
    } pqt_word_t;

    localparam logic [7:0] DIM_ROM [256] = '{
        8'd0,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
        8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
        8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd4,
        8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,
        8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,
        8'd5,   8'd5,   8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,
        8'd6,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
        8'd7,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd8,
        8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,
        8'd10,  8'd10,  8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd11,
        8'd11,  8'd11,  8'd12,  8'd12,  8'd12,  8'd12,  8'd12,  8'd13,
        8'd13,  8'd13,  8'd13,  8'd14,  8'd14,  8'd14,  8'd14,  8'd15,
        8'd15,  8'd15,  8'd16,  8'd16,  8'd16,  8'd16,  8'd17,  8'd17,
        8'd17,  8'd18,  8'd18,  8'd18,  8'd19,  8'd19,  8'd19,  8'd20,
        8'd20,  8'd20,  8'd21,  8'd21,  8'd22,  8'd22,  8'd22,  8'd23,
        8'd23,  8'd24,  8'd24,  8'd25,  8'd25,  8'd25,  8'd26,  8'd26,
        8'd27,  8'd27,  8'd28,  8'd28,  8'd29,  8'd29,  8'd30,  8'd30,
        8'd31,  8'd32,  8'd32,  8'd33,  8'd33,  8'd34,  8'd35,  8'd35,
        8'd36,  8'd36,  8'd37,  8'd38,  8'd38,  8'd39,  8'd40,  8'd40,
        8'd41,  8'd42,  8'd43,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,
        8'd48,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
        8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
        8'd63,  8'd64,  8'd65,  8'd66,  8'd68,  8'd69,  8'd70,  8'd71,
        8'd73,  8'd74,  8'd75,  8'd76,  8'd78,  8'd79,  8'd81,  8'd82,
        8'd83,  8'd85,  8'd86,  8'd88,  8'd90,  8'd91,  8'd93,  8'd94,
        8'd96,  8'd98,  8'd99,  8'd101, 8'd103, 8'd105, 8'd107, 8'd109,
        8'd110, 8'd112, 8'd114, 8'd116, 8'd118, 8'd121, 8'd123, 8'd125,
        8'd127, 8'd129, 8'd132, 8'd134, 8'd136, 8'd139, 8'd141, 8'd144,
        8'd146, 8'd149, 8'd151, 8'd154, 8'd157, 8'd159, 8'd162, 8'd165,
        8'd168, 8'd171, 8'd174, 8'd177, 8'd180, 8'd183, 8'd186, 8'd190,
        8'd193, 8'd196, 8'd200, 8'd203, 8'd207, 8'd211, 8'd214, 8'd218,
        8'd222, 8'd226, 8'd230, 8'd234, 8'd238, 8'd242, 8'd248, 8'd255
    };

endpackage

// ===== src/hsbrgb_lookup.sv =====
// Stage 1: dimming curve lookups for brightness and saturation, hue split into sector and
// remainder. Depends on hsbrgb_pkg.

module hsbrgb_lookup
    import hsbrgb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  hsb_t      in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output lkp_word_t out_word
);

    logic      valid_reg;
    lkp_word_t word_reg;
    lkp_word_t word_next;
    logic [7:0] base;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        word_next.v       = DIM_ROM[in_word.brightness];
        word_next.sat_inv = DIM_ROM[~in_word.saturation];
        word_next.black   = (word_next.v == 8'd0);
        word_next.grey    = (word_next.sat_inv == SAT_FULL);
        if (in_word.hue < 8'(SECTOR_SPAN))
        begin
            word_next.sector = SECTOR_RED_YEL;
            base             = 8'd0;
        end
        else if (in_word.hue < 8'(2 * SECTOR_SPAN))
        begin
            word_next.sector = SECTOR_YEL_GRN;
            base             = 8'(SECTOR_SPAN);
        end
        else if (in_word.hue < 8'(3 * SECTOR_SPAN))
        begin
            word_next.sector = SECTOR_GRN_CYN;
            base             = 8'(2 * SECTOR_SPAN);
        end
        else if (in_word.hue < 8'(4 * SECTOR_SPAN))
        begin
            word_next.sector = SECTOR_CYN_BLU;
            base             = 8'(3 * SECTOR_SPAN);
        end
        else if (in_word.hue < 8'(5 * SECTOR_SPAN))
        begin
            word_next.sector = SECTOR_BLU_MAG;
            base             = 8'(4 * SECTOR_SPAN);
        end
        else
        begin
            // top of the hue range folds into the last sector
            word_next.sector = SECTOR_MAG_RED;
            base             = 8'(5 * SECTOR_SPAN);
        end
        word_next.rem = 6'(in_word.hue - base);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== src/hsbrgb_mul.sv =====
// Stages 2 and 3: p = v * (255 - s) / 256, then the span products for q and t.
// Depends on hsbrgb_pkg.

module hsbrgb_mul
    import hsbrgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  lkp_word_t  in_word,
    output logic       out_valid,
    input  logic       out_ready,
    output prod_word_t out_word
);

    logic       pv_valid_reg;
    logic       pv_ready;
    pval_word_t pv_reg;
    pval_word_t pv_next;
    logic [15:0] p_full;

    logic       pr_valid_reg;
    prod_word_t pr_reg;
    prod_word_t pr_next;
    logic [7:0] span;

    // stage 2
    assign in_ready = !pv_valid_reg || pv_ready;
    assign p_full   = 16'(in_word.v) * 16'(in_word.sat_inv);

    always_comb
    begin
        pv_next.v      = in_word.v;
        pv_next.p      = p_full[15:8];
        pv_next.sector = in_word.sector;
        pv_next.rem    = in_word.rem;
        pv_next.black  = in_word.black;
        pv_next.grey   = in_word.grey;
    end

    // stage 3
    assign pv_ready  = !pr_valid_reg || out_ready;
    assign span      = pv_reg.v - pv_reg.p;
    assign out_valid = pr_valid_reg;
    assign out_word  = pr_reg;

    always_comb
    begin
        pr_next.v      = pv_reg.v;
        pr_next.p      = pv_reg.p;
        pr_next.prod_q = 14'(span) * 14'(6'(SECTOR_SPAN) - pv_reg.rem);
        pr_next.prod_t = 14'(span) * 14'(pv_reg.rem);
        pr_next.sector = pv_reg.sector;
        pr_next.black  = pv_reg.black;
        pr_next.grey   = pv_reg.grey;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_valid_reg <= 1'b0;
            pr_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                pv_valid_reg <= in_valid;
            end
            if (pv_ready)
            begin
                pr_valid_reg <= pv_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pv_reg <= pv_next;
        end
        if (pv_valid_reg && pv_ready)
        begin
            pr_reg <= pr_next;
        end
    end

endmodule

// ===== src/hsbrgb_div.sv =====
// Stage 4: floor division of both span products by 43 through a reciprocal multiply, plus p.
// Depends on hsbrgb_pkg.

module hsbrgb_div
    import hsbrgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  prod_word_t in_word,
    output logic       out_valid,
    input  logic       out_ready,
    output pqt_word_t  out_word
);

    logic        valid_reg;
    pqt_word_t   word_reg;
    pqt_word_t   word_next;
    logic [27:0] recip_q;
    logic [27:0] recip_t;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    assign recip_q = 28'(in_word.prod_q) * 28'(RECIP_43);
    assign recip_t = 28'(in_word.prod_t) * 28'(RECIP_43);

    always_comb
    begin
        word_next.v      = in_word.v;
        word_next.p      = in_word.p;
        // quotient plus p never exceeds v
        word_next.q      = recip_q[RECIP_SHIFT +: 8] + in_word.p;
        word_next.t      = recip_t[RECIP_SHIFT +: 8] + in_word.p;
        word_next.sector = in_word.sector;
        word_next.black  = in_word.black;
        word_next.grey   = in_word.grey;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== src/hsbrgb_order.sv =====
// Stage 5: orders v, p, q and t per sector, handles black and grey, holds the output word.
// Depends on hsbrgb_pkg.

module hsbrgb_order
    import hsbrgb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  pqt_word_t in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output rgb_t      out_word
);

    logic valid_reg;
    rgb_t word_reg;
    rgb_t word_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        if (in_word.black)
        begin
            word_next = '{red: 8'd0, green: 8'd0, blue: 8'd0};
        end
        else if (in_word.grey)
        begin
            word_next = '{red: in_word.v, green: in_word.v, blue: in_word.v};
        end
        else
        begin
            case (in_word.sector)
                SECTOR_RED_YEL: word_next = '{red: in_word.v, green: in_word.t, blue: in_word.p};
                SECTOR_YEL_GRN: word_next = '{red: in_word.q, green: in_word.v, blue: in_word.p};
                SECTOR_GRN_CYN: word_next = '{red: in_word.p, green: in_word.v, blue: in_word.t};
                SECTOR_CYN_BLU: word_next = '{red: in_word.p, green: in_word.q, blue: in_word.v};
                SECTOR_BLU_MAG: word_next = '{red: in_word.t, green: in_word.p, blue: in_word.v};
                default:        word_next = '{red: in_word.v, green: in_word.p, blue: in_word.q};
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== src/hsb_to_rgb_dim_curve.sv =====
// Top level of the HSB to RGB converter with perceptual dimming curve.
// Depends on hsbrgb_pkg, hsbrgb_lookup, hsbrgb_mul, hsbrgb_div and hsbrgb_order.

// Converts one hue/saturation/brightness word to one red/green/blue word per clock while
// the output is not stalled. The path is five register stages (curve lookups, p multiply,
// span multiplies, reciprocal divide by 43, sector ordering), and an accepted word passes
// through them in that order to the output. Each stage holds its word until the next one
// frees up, so a stalled output only stops input once all five stages are full; bubbles
// are squeezed out.
// There is no state and no configuration, and the block is ready right after reset.

module hsb_to_rgb_dim_curve
    import hsbrgb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic hsb_valid,
    output logic hsb_ready,
    input  hsb_t hsb,
    output logic rgb_valid,
    input  logic rgb_ready,
    output rgb_t rgb
);

    logic       lkp_valid;
    logic       lkp_ready;
    lkp_word_t  lkp_word;
    logic       prod_valid;
    logic       prod_ready;
    prod_word_t prod_word;
    logic       pqt_valid;
    logic       pqt_ready;
    pqt_word_t  pqt_word;

    hsbrgb_lookup u_lookup (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hsb_valid),
        .in_ready  (hsb_ready),
        .in_word   (hsb),
        .out_valid (lkp_valid),
        .out_ready (lkp_ready),
        .out_word  (lkp_word)
    );

    hsbrgb_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lkp_valid),
        .in_ready  (lkp_ready),
        .in_word   (lkp_word),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_word  (prod_word)
    );

    hsbrgb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_word   (prod_word),
        .out_valid (pqt_valid),
        .out_ready (pqt_ready),
        .out_word  (pqt_word)
    );

    hsbrgb_order u_order (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pqt_valid),
        .in_ready  (pqt_ready),
        .in_word   (pqt_word),
        .out_valid (rgb_valid),
        .out_ready (rgb_ready),
        .out_word  (rgb)
    );

endmodule

// ===== src/hsbrgb_checker.sv =====
// Port-level checker for hsb_to_rgb_dim_curve, bound to the top level.
// Depends on hsbrgb_pkg.

module hsbrgb_checker
    import hsbrgb_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic hsb_valid,
    input logic hsb_ready,
    input hsb_t hsb,
    input logic rgb_valid,
    input logic rgb_ready,
    input rgb_t rgb
);

    localparam logic [2:0] DEPTH = 3'd5;

    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;
    logic       in_take;
    logic       out_take;

    assign in_take  = hsb_valid && hsb_ready;
    assign out_take = rgb_valid && rgb_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_take && !out_take)
        begin
            inflight_next = inflight_reg + 3'd1;
        end
        else if (out_take && !in_take)
        begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 3'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // a waiting input word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hsb_valid && !hsb_ready |=> hsb_valid && $stable(hsb))
        else $error("input word changed while waiting");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid && !rgb_ready |=> rgb_valid && $stable(rgb))
        else $error("output word changed while stalled");

    // no word out without one in flight
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid |-> inflight_reg != 3'd0)
        else $error("output word with nothing in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= DEPTH)
        else $error("more words in flight than pipeline stages");

    // input only backs up when the pipe is full behind a stalled output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !hsb_ready |-> rgb_valid && !rgb_ready && inflight_reg == DEPTH)
        else $error("input stalled while pipeline had room");

endmodule

bind hsb_to_rgb_dim_curve hsbrgb_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .hsb_valid (hsb_valid),
    .hsb_ready (hsb_ready),
    .hsb       (hsb),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready),
    .rgb       (rgb)
);

// ===== test/hsb_to_rgb_dim_curve_tb.sv =====
// Self-checking testbench for hsb_to_rgb_dim_curve: a directed table then random words,
// each checked as typed or by an in-bench HSB to RGB predictor with its own dimming curve.
// Depends on hsbrgb_pkg and the hsb_to_rgb_dim_curve RTL.
`timescale 1ns / 100ps

module hsb_to_rgb_dim_curve_tb;
    import hsbrgb_pkg::*;

    localparam int unsigned HUE_SPAN       = 43;
    localparam int unsigned STALL_LIMIT    = 1000;
    localparam int unsigned HOLD_CYCLES    = 64;
    localparam int unsigned DRAIN_CYCLES   = 12;
    localparam int unsigned PHASE_WORDS    = 130;
    localparam int unsigned PRESSURE_WORDS = 30;

    // Perceptual dimming curve, index 0 leftmost
    localparam logic [0:255][7:0] CURVE_LUT = {
        8'd0,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
        8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
        8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd4,
        8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,
        8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,
        8'd5,   8'd5,   8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,
        8'd6,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
        8'd7,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd8,
        8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,   8'd9,
        8'd10,  8'd10,  8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd11,
        8'd11,  8'd11,  8'd12,  8'd12,  8'd12,  8'd12,  8'd12,  8'd13,
        8'd13,  8'd13,  8'd13,  8'd14,  8'd14,  8'd14,  8'd14,  8'd15,
        8'd15,  8'd15,  8'd16,  8'd16,  8'd16,  8'd16,  8'd17,  8'd17,
        8'd17,  8'd18,  8'd18,  8'd18,  8'd19,  8'd19,  8'd19,  8'd20,
        8'd20,  8'd20,  8'd21,  8'd21,  8'd22,  8'd22,  8'd22,  8'd23,
        8'd23,  8'd24,  8'd24,  8'd25,  8'd25,  8'd25,  8'd26,  8'd26,
        8'd27,  8'd27,  8'd28,  8'd28,  8'd29,  8'd29,  8'd30,  8'd30,
        8'd31,  8'd32,  8'd32,  8'd33,  8'd33,  8'd34,  8'd35,  8'd35,
        8'd36,  8'd36,  8'd37,  8'd38,  8'd38,  8'd39,  8'd40,  8'd40,
        8'd41,  8'd42,  8'd43,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,
        8'd48,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
        8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,  8'd62,
        8'd63,  8'd64,  8'd65,  8'd66,  8'd68,  8'd69,  8'd70,  8'd71,
        8'd73,  8'd74,  8'd75,  8'd76,  8'd78,  8'd79,  8'd81,  8'd82,
        8'd83,  8'd85,  8'd86,  8'd88,  8'd90,  8'd91,  8'd93,  8'd94,
        8'd96,  8'd98,  8'd99,  8'd101, 8'd103, 8'd105, 8'd107, 8'd109,
        8'd110, 8'd112, 8'd114, 8'd116, 8'd118, 8'd121, 8'd123, 8'd125,
        8'd127, 8'd129, 8'd132, 8'd134, 8'd136, 8'd139, 8'd141, 8'd144,
        8'd146, 8'd149, 8'd151, 8'd154, 8'd157, 8'd159, 8'd162, 8'd165,
        8'd168, 8'd171, 8'd174, 8'd177, 8'd180, 8'd183, 8'd186, 8'd190,
        8'd193, 8'd196, 8'd200, 8'd203, 8'd207, 8'd211, 8'd214, 8'd218,
        8'd222, 8'd226, 8'd230, 8'd234, 8'd238, 8'd242, 8'd248, 8'd255
    };

    typedef struct {
        hsb_t word;
        bit   typed;
        rgb_t want;
    } colour_vector_t;

    logic clk;
    logic rst_n;
    logic hsb_valid;
    logic hsb_ready;
    hsb_t hsb;
    logic rgb_valid;
    logic rgb_ready;
    rgb_t rgb;

    // Expectation attached to the word currently offered
    bit   word_typed;
    rgb_t word_want;

    rgb_t           rgb_expected [$];
    colour_vector_t directed_colours [$];
    rgb_t           oldest_rgb;
    int unsigned    mismatch_count;
    int unsigned    quiet_cycles;
    int unsigned    send_idle_pct;
    int unsigned    recv_idle_pct;
    bit             hold_req;

    hsb_to_rgb_dim_curve dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsb_valid (hsb_valid),
        .hsb_ready (hsb_ready),
        .hsb       (hsb),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb_ready),
        .rgb       (rgb)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic rgb_t hsb_dimmed_to_rgb(input hsb_t word);
        int unsigned v;
        int unsigned s;
        int unsigned rem;
        int unsigned sector;
        int unsigned p;
        int unsigned span;
        int unsigned q;
        int unsigned t;
        rgb_t        c;
        v = 32'(CURVE_LUT[word.brightness]);
        s = 255 - CURVE_LUT[255 - word.saturation];
        c = '0;
        if (v == 0)
        begin
            c = '0;
        end
        else if (s == 0)
        begin
            c.red   = v[7:0];
            c.green = v[7:0];
            c.blue  = v[7:0];
        end
        else
        begin
            rem    = word.hue % HUE_SPAN;
            sector = word.hue / HUE_SPAN;
            p      = (v * (255 - s)) >> 8;
            span   = v - p;
            q      = (span * (HUE_SPAN - rem)) / HUE_SPAN + p;
            t      = (span * rem) / HUE_SPAN + p;
            case (sector)
                SECTOR_RED_YEL: c = '{v[7:0], t[7:0], p[7:0]};
                SECTOR_YEL_GRN: c = '{q[7:0], v[7:0], p[7:0]};
                SECTOR_GRN_CYN: c = '{p[7:0], v[7:0], t[7:0]};
                SECTOR_CYN_BLU: c = '{p[7:0], q[7:0], v[7:0]};
                SECTOR_BLU_MAG: c = '{t[7:0], p[7:0], v[7:0]};
                default:        c = '{v[7:0], p[7:0], q[7:0]};
            endcase
        end
        return c;
    endfunction

    function automatic hsb_t random_hsb();
        hsb_t word;
        word.hue        = 8'($urandom_range(255));
        word.saturation = 8'($urandom_range(255));
        word.brightness = 8'($urandom_range(255));
        case ($urandom_range(7))
            0: word.brightness = 8'd0;
            1: word.saturation = 8'd0;
            // sector edges; hue 0 minus one wraps to 255, the top of the last sector
            2: word.hue = 8'(HUE_SPAN * $urandom_range(5) - $urandom_range(1));
            3:
            begin
                word.saturation = 8'd255;
                word.brightness = 8'd255;
            end
            default: ;
        endcase
        return word;
    endfunction

    task automatic add_vector(input logic [7:0] h, input logic [7:0] s, input logic [7:0] b,
                              input bit typed, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] bl);
        colour_vector_t row;
        row.word  = '{h, s, b};
        row.typed = typed;
        row.want  = '{r, g, bl};
        directed_colours.push_back(row);
    endtask

    // Called at a falling edge, returns at the falling edge after acceptance
    task automatic send_hsb(input hsb_t word, input bit typed, input rgb_t want);
        // each idle step is a fresh draw, so the idle share matches the percentage
        while ($urandom_range(99) < send_idle_pct)
        begin
            hsb_valid <= 1'b0;
            @(negedge clk);
        end
        hsb_valid  <= 1'b1;
        hsb        <= word;
        word_typed <= typed;
        word_want  <= want;
        @(posedge clk);
        while (!hsb_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_rgb_drained();
        hsb_valid <= 1'b0;
        @(negedge clk);
        while (rgb_expected.size() != 0)
            @(negedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        rgb_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                rgb_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            rgb_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result check first, then the newly accepted word's expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rgb_valid && rgb_ready)
            begin
                if (rgb_expected.size() == 0)
                begin
                    $error("rgb word %0d/%0d/%0d with nothing pending",
                           rgb.red, rgb.green, rgb.blue);
                    mismatch_count++;
                end
                else
                begin
                    oldest_rgb = rgb_expected.pop_front();
                    if (rgb.red !== oldest_rgb.red)
                    begin
                        $error("red: expected %0d, got %0d", oldest_rgb.red, rgb.red);
                        mismatch_count++;
                    end
                    if (rgb.green !== oldest_rgb.green)
                    begin
                        $error("green: expected %0d, got %0d", oldest_rgb.green, rgb.green);
                        mismatch_count++;
                    end
                    if (rgb.blue !== oldest_rgb.blue)
                    begin
                        $error("blue: expected %0d, got %0d", oldest_rgb.blue, rgb.blue);
                        mismatch_count++;
                    end
                end
            end
            if (hsb_valid && hsb_ready)
                rgb_expected.push_back(word_typed ? word_want : hsb_dimmed_to_rgb(hsb));
        end
    end

    always @(posedge clk)
    begin
        if ((hsb_valid && hsb_ready) || (rgb_valid && rgb_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[hsb_to_rgb_dim_curve] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        hsb_valid      = 1'b0;
        hsb            = '0;
        word_typed     = 1'b0;
        word_want      = '0;
        hold_req       = 1'b0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;

        // black whenever the dimmed brightness is zero
        add_vector(8'd0,   8'd0,   8'd0,   1, 8'd0,   8'd0,   8'd0);
        add_vector(8'd255, 8'd255, 8'd0,   1, 8'd0,   8'd0,   8'd0);
        // zero saturation gives grey at the dimmed brightness
        add_vector(8'd0,   8'd0,   8'd255, 1, 8'd255, 8'd255, 8'd255);
        add_vector(8'd100, 8'd0,   8'd128, 1, 8'd27,  8'd27,  8'd27);
        // full colour at each sector start, hues 42 and 214 and the top of the hue range
        add_vector(8'd0,   8'd255, 8'd255, 1, 8'd255, 8'd0,   8'd0);
        add_vector(8'd42,  8'd255, 8'd255, 1, 8'd255, 8'd249, 8'd0);
        add_vector(8'd43,  8'd255, 8'd255, 1, 8'd255, 8'd255, 8'd0);
        add_vector(8'd86,  8'd255, 8'd255, 1, 8'd0,   8'd255, 8'd0);
        add_vector(8'd129, 8'd255, 8'd255, 1, 8'd0,   8'd255, 8'd255);
        add_vector(8'd172, 8'd255, 8'd255, 1, 8'd0,   8'd0,   8'd255);
        add_vector(8'd214, 8'd255, 8'd255, 1, 8'd249, 8'd0,   8'd255);
        add_vector(8'd215, 8'd255, 8'd255, 1, 8'd255, 8'd0,   8'd255);
        add_vector(8'd255, 8'd255, 8'd255, 1, 8'd255, 8'd0,   8'd17);
        add_vector(8'd0,   8'd255, 8'd1,   1, 8'd1,   8'd0,   8'd0);
        add_vector(8'd128, 8'd128, 8'd128, 0, 8'd0,   8'd0,   8'd0);
        add_vector(8'd42,  8'd1,   8'd200, 0, 8'd0,   8'd0,   8'd0);
        add_vector(8'd216, 8'd254, 8'd254, 0, 8'd0,   8'd0,   8'd0);
        add_vector(8'd7,   8'd200, 8'd50,  0, 8'd0,   8'd0,   8'd0);
        add_vector(8'd170, 8'd77,  8'd255, 0, 8'd0,   8'd0,   8'd0);
        add_vector(8'd1,   8'd1,   8'd1,   0, 8'd0,   8'd0,   8'd0);
        add_vector(8'd100, 8'd170, 8'd85,  0, 8'd0,   8'd0,   8'd0);
        add_vector(8'd230, 8'd60,  8'd230, 0, 8'd0,   8'd0,   8'd0);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_colours[i])
            send_hsb(directed_colours[i].word, directed_colours[i].typed,
                     directed_colours[i].want);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 48;
                    recv_idle_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 48;
                end
                default:
                begin
                    send_idle_pct = 33;
                    recv_idle_pct = 33;
                end
            endcase
            repeat (PHASE_WORDS) send_hsb(random_hsb(), 1'b0, '0);
            if (phase == 0)
            begin
                // output held off while words keep coming: pipeline fills, input stalls
                hold_req = 1'b1;
                repeat (PRESSURE_WORDS) send_hsb(random_hsb(), 1'b0, '0);
            end
            wait_rgb_drained();
        end

        recv_idle_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("[hsb_to_rgb_dim_curve] OK");
        else
            $display("[hsb_to_rgb_dim_curve] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/hsbrgb_pkg.sv
src/hsbrgb_lookup.sv
src/hsbrgb_mul.sv
src/hsbrgb_div.sv
src/hsbrgb_order.sv
src/hsb_to_rgb_dim_curve.sv
src/hsbrgb_checker.sv
test/hsb_to_rgb_dim_curve_tb.sv
